@@ rtl/core/wcuc_pkg.sv @@
// ---------------------------------------------------------------------------
// wcuc_pkg: shared types and constants of the window uniformity classifier
// Widths, register defaults, verdict codes and the queue entry layout.
// ---------------------------------------------------------------------------
`default_nettype none
package wcuc_pkg;

    localparam int PIX_W             = 8;
    localparam int ROW_W             = 8;
    localparam int COL_W             = 8;
    localparam int CUT_W             = 9;
    localparam int THR_W             = 8;
    localparam int MAX_WINDOW_PIXELS = 4096;
    localparam int GRID_ROWS         = 256;
    localparam int CNT_W             = $clog2(MAX_WINDOW_PIXELS + 1);
    localparam int SUM_W             = $clog2(MAX_WINDOW_PIXELS * 255 + 1);
    localparam int PROD_W            = PIX_W + CNT_W;
    localparam int CMP_W             = PROD_W + 1;
    localparam int MARK_W            = 8;
    localparam int WHY_W             = 2;
    localparam int Q_DEPTH           = 4;
    localparam int Q_PTR_W           = $clog2(Q_DEPTH);
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 9;

    localparam logic [MARK_W-1:0] MARK_PASS = 8'd255;
    localparam logic [MARK_W-1:0] MARK_FAIL = 8'd0;

    localparam logic [CUT_W-1:0] TOP_CUT_RST    = CUT_W'(0);
    localparam logic [CUT_W-1:0] BOTTOM_CUT_RST = CUT_W'(GRID_ROWS);
    localparam logic [THR_W-1:0] SPREAD_RST     = 8'd20;
    localparam logic [THR_W-1:0] GREY_RST       = 8'd50;

    typedef enum logic [WHY_W-1:0] {
        WHY_OK     = 2'd0,
        WHY_ROW    = 2'd1,
        WHY_SPREAD = 2'd2,
        WHY_GREY   = 2'd3
    } t_why;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_CUT    = 2'd0,
        CFG_BOTTOM_CUT = 2'd1,
        CFG_SPREAD     = 2'd2,
        CFG_GREY       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CUT_W-1:0] top_cut;
        logic [CUT_W-1:0] bottom_cut;
        logic [THR_W-1:0] spread;
        logic [THR_W-1:0] grey;
    } t_cfg;

    // window totals handed from accumulator to judge
    typedef struct packed {
        logic [SUM_W-1:0] sum_a;
        logic [SUM_W-1:0] sum_b;
        logic [SUM_W-1:0] sum_c;
        logic [PIX_W-1:0] peak_a;
        logic [PIX_W-1:0] peak_b;
        logic [PIX_W-1:0] peak_c;
        logic [CNT_W-1:0] count;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_snap;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

@@ rtl/core/wcuc_front.sv @@
// ---------------------------------------------------------------------------
// wcuc_front: pixel accumulator
// Keeps per-channel sums, peaks and pixel count; on the last pixel of a
// window pushes the totals into the totals queue and clears.
// ---------------------------------------------------------------------------
`default_nettype none
module wcuc_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [wcuc_pkg::PIX_W-1:0] i_chan_a,
    input  wire logic [wcuc_pkg::PIX_W-1:0] i_chan_b,
    input  wire logic [wcuc_pkg::PIX_W-1:0] i_chan_c,
    input  wire logic [wcuc_pkg::ROW_W-1:0] i_block_row,
    input  wire logic [wcuc_pkg::COL_W-1:0] i_block_col,
    input  wire logic                   i_window_end,
    input  wire wcuc_pkg::t_q_stat      i_q_stat,
    output logic                        o_push,
    output wcuc_pkg::t_snap             o_snap
);
    import wcuc_pkg::*;

    logic [SUM_W-1:0] r_sum_a, r_sum_b, r_sum_c;
    logic [SUM_W-1:0] n_sum_a, n_sum_b, n_sum_c;
    logic [PIX_W-1:0] r_peak_a, r_peak_b, r_peak_c;
    logic [PIX_W-1:0] n_peak_a, n_peak_b, n_peak_c;
    logic [CNT_W-1:0] r_count, n_count;
    logic             take;
    logic             room;

    assign o_ready = !i_q_stat.full;
    assign take    = i_valid && o_ready;
    // pixels past the window limit are dropped from all totals
    assign room    = r_count < CNT_W'(MAX_WINDOW_PIXELS);

    always_comb begin
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        n_sum_c  = r_sum_c;
        n_peak_a = r_peak_a;
        n_peak_b = r_peak_b;
        n_peak_c = r_peak_c;
        n_count  = r_count;
        if (room) begin
            n_sum_a  = r_sum_a + {{(SUM_W-PIX_W){1'b0}}, i_chan_a};
            n_sum_b  = r_sum_b + {{(SUM_W-PIX_W){1'b0}}, i_chan_b};
            n_sum_c  = r_sum_c + {{(SUM_W-PIX_W){1'b0}}, i_chan_c};
            n_peak_a = (i_chan_a > r_peak_a) ? i_chan_a : r_peak_a;
            n_peak_b = (i_chan_b > r_peak_b) ? i_chan_b : r_peak_b;
            n_peak_c = (i_chan_c > r_peak_c) ? i_chan_c : r_peak_c;
            n_count  = r_count + 1'b1;
        end
    end

    assign o_push        = take && i_window_end;
    assign o_snap.sum_a  = n_sum_a;
    assign o_snap.sum_b  = n_sum_b;
    assign o_snap.sum_c  = n_sum_c;
    assign o_snap.peak_a = n_peak_a;
    assign o_snap.peak_b = n_peak_b;
    assign o_snap.peak_c = n_peak_c;
    assign o_snap.count  = n_count;
    assign o_snap.row    = i_block_row;
    assign o_snap.col    = i_block_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_sum_a  <= '0;
            r_sum_b  <= '0;
            r_sum_c  <= '0;
            r_peak_a <= '0;
            r_peak_b <= '0;
            r_peak_c <= '0;
            r_count  <= '0;
        end else if (take) begin
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
            r_sum_c  <= n_sum_c;
            r_peak_a <= n_peak_a;
            r_peak_b <= n_peak_b;
            r_peak_c <= n_peak_c;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/wcuc_queue.sv @@
// ---------------------------------------------------------------------------
// wcuc_queue: window totals queue
// Small register FIFO between the accumulator and the judge.
// ---------------------------------------------------------------------------
`default_nettype none
module wcuc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire wcuc_pkg::t_snap   i_snap,
    input  wire logic              i_pop,
    output wcuc_pkg::t_snap        o_head,
    output wcuc_pkg::t_q_stat      o_stat
);
    import wcuc_pkg::*;

    t_snap              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_stat.full  = r_cnt == (Q_PTR_W+1)'(Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_snap;
    end

endmodule
`default_nettype wire

@@ rtl/core/wcuc_back.sv @@
// ---------------------------------------------------------------------------
// wcuc_back: window judge
// Stage 1 scales peaks and thresholds by the count and takes absolute sum
// differences; stage 2 compares, prioritizes and holds the verdict.
// ---------------------------------------------------------------------------
`default_nettype none
module wcuc_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire wcuc_pkg::t_cfg             i_cfg,
    input  wire wcuc_pkg::t_snap            i_head,
    input  wire wcuc_pkg::t_q_stat          i_q_stat,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [wcuc_pkg::MARK_W-1:0]     o_mark,
    output logic [wcuc_pkg::WHY_W-1:0]      o_why,
    output logic [wcuc_pkg::ROW_W-1:0]      o_out_row,
    output logic [wcuc_pkg::COL_W-1:0]      o_out_col
);
    import wcuc_pkg::*;

    logic              r_s1_valid;
    logic [PROD_W-1:0] r_pkn_a, r_pkn_b, r_pkn_c;
    logic [PROD_W-1:0] r_tn, r_gn;
    logic [SUM_W-1:0]  r_sum_a, r_sum_b, r_sum_c;
    logic [SUM_W-1:0]  r_d_ba, r_d_bc, r_d_ac;
    logic              r_cut;
    logic [ROW_W-1:0]  r_s1_row;
    logic [COL_W-1:0]  r_s1_col;

    logic              r_out_valid;
    logic [MARK_W-1:0] r_out_mark;
    t_why              r_out_why;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;

    logic              out_free, s1_free;
    logic              spr_a, spr_b, spr_c, gry_ba, gry_bc, gry_ac;
    t_why              n_why;
    logic [PROD_W-1:0] cnt_x;

    assign out_free = !r_out_valid || i_ready;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_pop    = s1_free && !i_q_stat.empty;
    assign cnt_x    = PROD_W'(i_head.count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pkn_a  <= PROD_W'(i_head.peak_a) * cnt_x;
            r_pkn_b  <= PROD_W'(i_head.peak_b) * cnt_x;
            r_pkn_c  <= PROD_W'(i_head.peak_c) * cnt_x;
            r_tn     <= PROD_W'(i_cfg.spread) * cnt_x;
            r_gn     <= PROD_W'(i_cfg.grey) * cnt_x;
            r_sum_a  <= i_head.sum_a;
            r_sum_b  <= i_head.sum_b;
            r_sum_c  <= i_head.sum_c;
            r_d_ba   <= (i_head.sum_b >= i_head.sum_a) ? i_head.sum_b - i_head.sum_a
                                                       : i_head.sum_a - i_head.sum_b;
            r_d_bc   <= (i_head.sum_b >= i_head.sum_c) ? i_head.sum_b - i_head.sum_c
                                                       : i_head.sum_c - i_head.sum_b;
            r_d_ac   <= (i_head.sum_a >= i_head.sum_c) ? i_head.sum_a - i_head.sum_c
                                                       : i_head.sum_c - i_head.sum_a;
            r_cut    <= ({1'b0, i_head.row} < i_cfg.top_cut) ||
                        ({1'b0, i_head.row} > i_cfg.bottom_cut);
            r_s1_row <= i_head.row;
            r_s1_col <= i_head.col;
        end
    end

    // max*n >= sum + T*n stands in for max - mean >= T
    assign spr_a  = {1'b0, r_pkn_a} >= (CMP_W'(r_sum_a) + CMP_W'(r_tn));
    assign spr_b  = {1'b0, r_pkn_b} >= (CMP_W'(r_sum_b) + CMP_W'(r_tn));
    assign spr_c  = {1'b0, r_pkn_c} >= (CMP_W'(r_sum_c) + CMP_W'(r_tn));
    assign gry_ba = PROD_W'(r_d_ba) >= r_gn;
    assign gry_bc = PROD_W'(r_d_bc) >= r_gn;
    assign gry_ac = PROD_W'(r_d_ac) >= r_gn;

    always_comb begin
        if (r_cut) begin
            n_why = WHY_ROW;
        end else if (spr_a || spr_b || spr_c) begin
            n_why = WHY_SPREAD;
        end else if (gry_ba || gry_bc || gry_ac) begin
            n_why = WHY_GREY;
        end else begin
            n_why = WHY_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_why  <= n_why;
            r_out_mark <= (n_why == WHY_OK) ? MARK_PASS : MARK_FAIL;
            r_out_row  <= r_s1_row;
            r_out_col  <= r_s1_col;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_mark    = r_out_mark;
    assign o_why     = r_out_why;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;

endmodule
`default_nettype wire

@@ rtl/core/window_color_uniformity_classifier_unit.sv @@
// ---------------------------------------------------------------------------
// window_color_uniformity_classifier_unit: window uniformity classifier
// Accumulates pixel channels per window and emits one verdict per window.
//
// Input channel (i_valid/o_ready): one pixel per item, up to one per cycle.
// Three channels, the window's block row/column and a last-pixel flag.
// Output channel (o_valid/i_ready): one verdict item per window, mark 255
// for a uniform grey-like window, else 0, with the reason code in o_why.
// Config channel (i_cfg_valid/o_cfg_ready): always ready, one register
// write per cycle; write only while no window is in flight.
// Path: a window's totals are written to the queue at the edge that
// accepts its last pixel, then pass the scaling stage and the compare
// stage before its verdict is valid.
// Throughput: one pixel per cycle while o_ready is high; back to back
// single-pixel windows also run at one per cycle while the receiver keeps up.
// Stall: verdicts wait in the output register, the scaling stage and a
// 4-entry totals queue; once the queue is full o_ready drops until the
// judge takes an entry from it.
// Reset: clears the accumulators, queue and pipeline; registers return to
// top cut 0, bottom cut 256, spread 20, grey 50.
// ---------------------------------------------------------------------------
`default_nettype none
module window_color_uniformity_classifier_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [wcuc_pkg::PIX_W-1:0]     i_chan_a,
    input  wire logic [wcuc_pkg::PIX_W-1:0]     i_chan_b,
    input  wire logic [wcuc_pkg::PIX_W-1:0]     i_chan_c,
    input  wire logic [wcuc_pkg::ROW_W-1:0]     i_block_row,
    input  wire logic [wcuc_pkg::COL_W-1:0]     i_block_col,
    input  wire logic                           i_window_end,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [wcuc_pkg::MARK_W-1:0]         o_mark,
    output logic [wcuc_pkg::WHY_W-1:0]          o_why,
    output logic [wcuc_pkg::ROW_W-1:0]          o_out_row,
    output logic [wcuc_pkg::COL_W-1:0]          o_out_col,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [wcuc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [wcuc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wcuc_pkg::*;

    t_cfg    r_cfg;
    t_snap   snap, head;
    t_q_stat q_stat;
    logic    push, pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top_cut    <= TOP_CUT_RST;
            r_cfg.bottom_cut <= BOTTOM_CUT_RST;
            r_cfg.spread     <= SPREAD_RST;
            r_cfg.grey       <= GREY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TOP_CUT:    r_cfg.top_cut    <= i_cfg_data[CUT_W-1:0];
                CFG_BOTTOM_CUT: r_cfg.bottom_cut <= i_cfg_data[CUT_W-1:0];
                CFG_SPREAD:     r_cfg.spread     <= i_cfg_data[THR_W-1:0];
                CFG_GREY:       r_cfg.grey       <= i_cfg_data[THR_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    wcuc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_chan_a     (i_chan_a),
        .i_chan_b     (i_chan_b),
        .i_chan_c     (i_chan_c),
        .i_block_row  (i_block_row),
        .i_block_col  (i_block_col),
        .i_window_end (i_window_end),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_snap       (snap)
    );

    wcuc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_snap  (snap),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    wcuc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_head    (head),
        .i_q_stat  (q_stat),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_mark    (o_mark),
        .o_why     (o_why),
        .o_out_row (o_out_row),
        .o_out_col (o_out_col)
    );

endmodule
`default_nettype wire

@@ rtl/core/wcuc_chk.sv @@
// ---------------------------------------------------------------------------
// wcuc_chk: port-level checks for the classifier
// Verdict coding, output hold under stall and reset behavior.
// ---------------------------------------------------------------------------
`default_nettype none
module wcuc_chk (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       o_ready,
    input  wire logic                       o_valid,
    input  wire logic                       i_ready,
    input  wire logic [wcuc_pkg::MARK_W-1:0] o_mark,
    input  wire logic [wcuc_pkg::WHY_W-1:0]  o_why,
    input  wire logic [wcuc_pkg::ROW_W-1:0]  o_out_row,
    input  wire logic [wcuc_pkg::COL_W-1:0]  o_out_col
);
    import wcuc_pkg::*;

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_mark, o_why, o_out_row, o_out_col}))
        else $error("verdict changed while stalled");

    // pass mark goes with the accept code only
    a_mark_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_why == WHY_OK) && (o_mark == MARK_PASS)) ||
                    ((o_why != WHY_OK) && (o_mark == MARK_FAIL)))
        else $error("mark does not match reason code");

    // no verdict straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("verdict valid after reset");

    // the queue is empty after reset, so pixels are taken right away
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready after reset");

    // an item taken in the cycle after reset cannot already be judged
    a_first_gap: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |=> !o_valid)
        else $error("verdict too early after reset");

endmodule

bind window_color_uniformity_classifier_unit wcuc_chk u_wcuc_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_mark    (o_mark),
    .o_why     (o_why),
    .o_out_row (o_out_row),
    .o_out_col (o_out_col)
);
`default_nettype wire
